@@ design/jsu_pkg.sv @@
`default_nettype none
package jsu_pkg;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_UNEXPECTED_END = 2'd1,
    ST_BAD_HEX        = 2'd2,
    ST_NOT_STRING     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_HEX0 = 3'd3,
    M_HEX1 = 3'd4,
    M_HEX2 = 3'd5,
    M_HEX3 = 3'd6
  } mode_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nb;
    logic            finish;
    status_t         status;
  } group_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_B:    r = 8'h08;
      CH_F:    r = 8'h0C;
      CH_N:    r = 8'h0A;
      CH_R:    r = 8'h0D;
      CH_T:    r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    else r = 5'h10;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/jsu_in_if.sv @@
`default_nettype none
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface
`default_nettype wire

@@ design/jsu_out_if.sv @@
`default_nettype none
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic [1:0] status;
  logic       run_last;

  modport source (output valid, out_byte, byte_valid, string_done, status, run_last,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, string_done, status, run_last,
                output ready);
endinterface
`default_nettype wire

@@ design/jsu_front.sv @@
`default_nettype none
module jsu_front
  import jsu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  jsu_in_if.sink      in_ch,
  input  wire qstat_t qstat,
  output logic        push,
  output group_t      group
);

  mode_t       mode, mode_next;
  logic [11:0] hex_accum, hex_accum_next;
  logic [4:0]  d;
  logic [15:0] cp;
  logic        accept;

  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign d           = hex_value(in_ch.in_byte);
  assign cp          = {hex_accum, d[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      hex_accum <= 12'd0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_accum <= hex_accum_next;
    end
  end

  always_comb begin
    mode_next      = mode;
    hex_accum_next = hex_accum;
    group.bytes    = '0;
    group.nb       = 2'd0;
    group.finish   = 1'b0;
    group.status   = ST_OK;
    case (mode)
      M_IDLE: begin
        if (in_ch.in_byte == CH_QUOTE) mode_next = M_STR;
        else begin
          group.finish = 1'b1;
          group.status = ST_NOT_STRING;
        end
      end
      M_STR: begin
        if (in_ch.in_byte == CH_QUOTE) group.finish = 1'b1;
        else if (in_ch.in_byte == CH_BACKSLASH) mode_next = M_ESC;
        else begin
          group.bytes[0] = in_ch.in_byte;
          group.nb       = 2'd1;
        end
      end
      M_ESC: begin
        if (in_ch.in_byte == CH_U) begin
          mode_next      = M_HEX0;
          hex_accum_next = 12'd0;
        end else begin
          group.bytes[0] = escape_map(in_ch.in_byte);
          group.nb       = 2'd1;
          mode_next      = M_STR;
        end
      end
      M_HEX0, M_HEX1, M_HEX2: begin
        if (d[4]) begin
          group.finish = 1'b1;
          group.status = ST_BAD_HEX;
        end else begin
          hex_accum_next = {hex_accum[7:0], d[3:0]};
          mode_next      = mode_t'(mode + 3'd1);
        end
      end
      M_HEX3: begin
        if (d[4]) begin
          group.finish = 1'b1;
          group.status = ST_BAD_HEX;
        end else begin
          if (cp[15:7] == 9'd0) begin
            group.bytes[0] = cp[7:0];
            group.nb       = 2'd1;
          end else if (cp[15:11] == 5'd0) begin
            group.bytes[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
            group.bytes[1] = UTF8_CONT | {2'd0, cp[5:0]};
            group.nb       = 2'd2;
          end else begin
            group.bytes[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
            group.bytes[1] = UTF8_CONT | {2'd0, cp[11:6]};
            group.bytes[2] = UTF8_CONT | {2'd0, cp[5:0]};
            group.nb       = 2'd3;
          end
          hex_accum_next = 12'd0;
          mode_next      = M_STR;
        end
      end
      default: begin
        group.finish = 1'b1;
        group.status = ST_BAD_HEX;
      end
    endcase
    // string still open when the text runs out
    if (!group.finish && in_ch.end_of_input && mode_next != M_IDLE) begin
      group.finish = 1'b1;
      group.status = ST_UNEXPECTED_END;
    end
    if (group.finish) begin
      mode_next      = M_IDLE;
      hex_accum_next = 12'd0;
    end
    push = accept && (group.finish || group.nb != 2'd0);
  end

endmodule
`default_nettype wire

@@ design/jsu_queue.sv @@
`default_nettype none
module jsu_queue
  import jsu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire group_t push_group,
  input  wire logic   pop,
  output group_t      head,
  output qstat_t      qstat
);

  group_t              entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_W-1:0] count;
  logic                do_push, do_pop;

  assign qstat.empty = (count == QCOUNT_W'(0));
  assign qstat.full  = (count == QCOUNT_W'(QDEPTH));
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_group;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + QCOUNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCOUNT_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ design/jsu_back.sv @@
`default_nettype none
module jsu_back
  import jsu_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire group_t head,
  input  wire qstat_t qstat,
  output logic        pop,
  jsu_out_if.source   out_ch
);

  logic [1:0] k;
  logic [1:0] nres;
  logic       last;
  logic       has_byte;
  logic [7:0] sel_byte;

  assign nres     = (head.nb == 2'd0) ? 2'd1 : head.nb;
  assign last     = (k == nres - 2'd1);
  assign has_byte = (k < head.nb);

  always_comb begin
    case (k)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      2'd2:    sel_byte = head.bytes[2];
      default: sel_byte = 8'd0;
    endcase
  end

  assign out_ch.valid       = !qstat.empty;
  assign out_ch.out_byte    = has_byte ? sel_byte : 8'd0;
  assign out_ch.byte_valid  = has_byte;
  assign out_ch.string_done = head.finish && last;
  assign out_ch.status      = (head.finish && last) ? head.status : ST_OK;
  assign out_ch.run_last    = last;
  assign pop                = out_ch.valid && out_ch.ready && last;

  // position within the current group
  always_ff @(posedge clk) begin
    if (rst) k <= 2'd0;
    else if (out_ch.valid && out_ch.ready) k <= last ? 2'd0 : k + 2'd1;
  end

endmodule
`default_nettype wire

@@ design/json_string_unescape.sv @@
// path: parser results are registered in the group queue and read from its head by the sequencer
// throughput: one input byte per cycle; output one result per cycle while ready, up to three
// per byte, with a four-group queue between parser and output sequencer
// input stalls only when that queue is full
// reset: synchronous, clears parser mode, hex accumulator, queue and sequencer
`default_nettype none
module json_string_unescape
  import jsu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic   push, pop;
  group_t push_group, head;
  qstat_t qstat;

  jsu_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push),
    .group (push_group)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  jsu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

@@ verif/tb_json_string_unescape.sv @@
`default_nettype none
module tb_json_string_unescape;
  import jsu_pkg::*;

  localparam int LIMIT_CYCLES    = 200000;
  localparam int TEXT_ITEMS      = 300;
  localparam int HOLD_OFF_AT     = 80;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int SETTLE_CYCLES   = 20;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    status_t    status;
    logic       run_last;
  } unesc_result_t;

  typedef struct {
    logic [7:0] c;
    logic       eoi;
    bit         drain_first;
  } text_byte_t;

  class unescape_scoreboard;
    mode_t         mode;
    logic [11:0]   acc;
    unesc_result_t pending[$];
    int            errors;

    function new();
      mode   = M_IDLE;
      acc    = '0;
      errors = 0;
    endfunction

    static function int hex_digit(logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
      if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
      if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    // works out the decoded bytes and end flags for one accepted text byte
    function void note_byte(logic [7:0] c, logic eoi);
      logic [7:0]    dec[3];
      int            nb;
      int            nres;
      int            d;
      int            k;
      bit            finish;
      status_t       st;
      logic [15:0]   cp;
      unesc_result_t r;
      nb     = 0;
      finish = 0;
      st     = ST_OK;
      case (mode)
        M_IDLE: begin
          if (c == CH_QUOTE) mode = M_STR;
          else begin
            finish = 1;
            st     = ST_NOT_STRING;
          end
        end
        M_STR: begin
          if (c == CH_QUOTE) finish = 1;
          else if (c == CH_BACKSLASH) mode = M_ESC;
          else begin
            dec[0] = c;
            nb     = 1;
          end
        end
        M_ESC: begin
          if (c == CH_U) begin
            mode = M_HEX0;
            acc  = '0;
          end else begin
            case (c)
              CH_B:    dec[0] = 8'h08;
              CH_F:    dec[0] = 8'h0C;
              CH_N:    dec[0] = 8'h0A;
              CH_R:    dec[0] = 8'h0D;
              CH_T:    dec[0] = 8'h09;
              default: dec[0] = c;
            endcase
            nb   = 1;
            mode = M_STR;
          end
        end
        default: begin
          d = hex_digit(c);
          if (d < 0) begin
            finish = 1;
            st     = ST_BAD_HEX;
          end else if (mode != M_HEX3) begin
            acc  = {acc[7:0], d[3:0]};
            mode = mode_t'(mode + 1);
          end else begin
            cp = {acc, d[3:0]};
            if (cp <= 16'h007F) begin
              dec[0] = cp[7:0];
              nb     = 1;
            end else if (cp <= 16'h07FF) begin
              dec[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
              dec[1] = UTF8_CONT | {2'b00, cp[5:0]};
              nb     = 2;
            end else begin
              dec[0] = UTF8_LEAD3 | {4'h0, cp[15:12]};
              dec[1] = UTF8_CONT | {2'b00, cp[11:6]};
              dec[2] = UTF8_CONT | {2'b00, cp[5:0]};
              nb     = 3;
            end
            acc  = '0;
            mode = M_STR;
          end
        end
      endcase
      // text runs out with a string still open
      if (!finish && eoi && mode != M_IDLE) begin
        finish = 1;
        st     = ST_UNEXPECTED_END;
      end
      if (finish) begin
        mode = M_IDLE;
        acc  = '0;
      end
      nres = (finish && nb == 0) ? 1 : nb;
      for (k = 0; k < nres; k++) begin
        r.out_byte    = (k < nb) ? dec[k] : 8'h00;
        r.byte_valid  = (k < nb);
        r.string_done = finish && (k == nres - 1);
        r.status      = r.string_done ? st : ST_OK;
        r.run_last    = (k == nres - 1);
        pending.push_back(r);
      end
    endfunction

    function void check_result(unesc_result_t got);
      unesc_result_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: out_byte %h byte_valid %b string_done %b",
               got.out_byte, got.byte_valid, got.string_done);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %b, actual %b", want.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.string_done !== want.string_done) begin
        $error("string_done: expected %b, actual %b", want.string_done, got.string_done);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   results_seen = 0;
  bit   draining = 0;

  unescape_scoreboard sb;
  text_byte_t         text[$];

  jsu_in_if  in_ch();
  jsu_out_if out_ch();

  json_string_unescape u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] c, logic eoi);
    text_byte_t t;
    t.c           = c;
    t.eoi         = eoi;
    t.drain_first = 0;
    text.push_back(t);
  endfunction

  function automatic void push_text(string s, logic eoi_last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], eoi_last && (i == s.len() - 1));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (unescape_scoreboard::hex_digit(c) >= 0);
    return c;
  endfunction

  function automatic logic [15:0] pick_code_point();
    logic [15:0] edges[6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
      3:       return edges[$urandom_range(0, 5)];
      4:       return 16'($urandom_range(16'hD800, 16'hDFFF));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // kind 0: well formed, 1: cut short by end of input, 2: bad hex digit
  function automatic void add_string(int kind);
    logic [7:0]  esc_set[8] = '{CH_QUOTE, CH_BACKSLASH, 8'h2F, CH_B, CH_F, CH_N, CH_R, CH_T};
    logic [7:0]  s[$];
    logic [7:0]  c;
    logic [15:0] cp;
    int          n_elems;
    int          n_dig;
    int          cut;
    s.push_back(CH_QUOTE);
    n_elems = $urandom_range(0, 8);
    for (int e = 0; e < n_elems; e++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
          s.push_back(c);
        end
        5, 6: begin
          s.push_back(CH_BACKSLASH);
          if ($urandom_range(0, 1)) s.push_back(esc_set[$urandom_range(0, 7)]);
          else begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_U);
            s.push_back(c);
          end
        end
        default: begin
          cp = pick_code_point();
          s.push_back(CH_BACKSLASH);
          s.push_back(CH_U);
          for (int i = 3; i >= 0; i--) s.push_back(hex_char(cp[4*i +: 4]));
        end
      endcase
    end
    if (kind == 2) begin
      s.push_back(CH_BACKSLASH);
      s.push_back(CH_U);
      n_dig = $urandom_range(0, 3);
      for (int i = 0; i < n_dig; i++) s.push_back(hex_char(4'($urandom_range(0, 15))));
      s.push_back(non_hex_byte());
      foreach (s[i]) push_byte(s[i], (i == s.size() - 1) && ($urandom_range(0, 3) == 0));
    end else begin
      s.push_back(CH_QUOTE);
      if (kind == 1) begin
        cut = $urandom_range(0, s.size() - 2);
        for (int i = 0; i <= cut; i++) push_byte(s[i], i == cut);
      end else begin
        foreach (s[i]) push_byte(s[i], (i == s.size() - 1) && ($urandom_range(0, 7) == 0));
      end
    end
  endfunction

  function automatic void build_text();
    int n_noise;
    int first_random;
    // stray bytes in idle, raw extremes, mapped and literal escapes, utf-8 widths
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_text("\"", 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_text("\\n\\x\\u07fF\\uFFFF\"", 1'b1);
    // quote that is also the last byte, bad hex with end, end inside a string
    push_text("\"", 1'b1);
    push_text("\"\\uG", 1'b1);
    push_text("\"a", 1'b1);
    first_random = text.size();
    while (text.size() < TEXT_ITEMS) begin
      case ($urandom_range(0, 19))
        13, 14:     add_string(1);
        15, 16:     add_string(2);
        17, 18, 19: begin
          n_noise = $urandom_range(1, 3);
          for (int i = 0; i < n_noise; i++)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        default:    add_string(0);
      endcase
    end
    text[first_random].drain_first = 1;
    text[(first_random + text.size()) / 2].drain_first = 1;
  endfunction

  task automatic send_byte(text_byte_t t, int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= t.c;
    in_ch.end_of_input <= t.eoi;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(t.c, t.eoi);
  endtask

  task automatic take_result(int stall);
    unesc_result_t got;
    @(negedge clk);
    if (stall > 0) begin
      out_ch.ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_ch.ready <= 1'b1;
    do @(posedge clk); while (!out_ch.valid);
    got.out_byte    = out_ch.out_byte;
    got.byte_valid  = out_ch.byte_valid;
    got.string_done = out_ch.string_done;
    got.status      = status_t'(out_ch.status);
    got.run_last    = out_ch.run_last;
    sb.check_result(got);
    results_seen++;
  endtask

  initial begin
    bit quiet;
    bit held;
    int stall;
    out_ch.ready = 1'b0;
    quiet = 0;
    held  = 0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      stall = quiet ? 0 : $urandom_range(0, 5);
      // one long hold-off so the group queue fills and the input stalls
      if (!held && !draining && results_seen >= HOLD_OFF_AT) begin
        stall = HOLD_OFF_CYCLES;
        held  = 1;
      end
      take_result(stall);
    end
  end

  initial begin
    bit quiet;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.end_of_input = 1'b0;
    sb = new();
    build_text();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    quiet = 0;
    foreach (text[i]) begin
      if (text[i].drain_first) begin
        draining = 1;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        draining = 0;
      end
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      send_byte(text[i], quiet ? 0 : $urandom_range(0, 5));
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
design/jsu_pkg.sv
design/jsu_in_if.sv
design/jsu_out_if.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape.sv
verif/tb_json_string_unescape.sv
